/* hw/rtl/vertex_normal_averager_core_assert.svh */
// assertion macros for the vertex normal averager core
// expects clk_i and rst_ni in the including module's scope
`ifndef VERTEX_NORMAL_AVERAGER_CORE_ASSERT_SVH
`define VERTEX_NORMAL_AVERAGER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vna_pkg.sv */
// shared types and constants for the vertex normal averager
// no dependencies
package vna_pkg;

  localparam int unsigned VERTEX_COUNT = 4096;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned NRM_W        = 16;
  localparam int unsigned SUM_W        = 32;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned DIV_STEPS    = SUM_W;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);
  localparam int unsigned RES_SLOTS    = 9;
  localparam int unsigned SLOT_W       = $clog2(RES_SLOTS);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_QRY_RD,
    ST_QRY_LOAD,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic        [CNT_W-1:0] cnt;
  } entry_t;

endpackage

/* hw/rtl/vertex_normal_averager_core.sv */
// vertex normal averager: per-vertex normal sums, use counts and averaged readout
// depends on vna_pkg and vertex_normal_averager_core_assert.svh
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   action, three vertex indices, face normal
//   out      source     out_valid_o / out_stall_i nine averaged components, status
//
// accumulate, from accept to the next accept: the accept cycle, then
//   read then write per corner (one store port each way)
// query: the accept cycle, the finished state, and per corner a store read and load
//   plus one pass of the shared one-bit-per-cycle divider per component; a zero-count
//   corner skips the divider
// clear: the accept cycle, then one store entry a cycle over all 4096 entries; the same
//   pass runs after reset, during which no item is accepted
// a finished query result sits in an output register, so a stalled output still
//   lets the next item in; a second finished query waits until that register frees
module vertex_normal_averager_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [vna_pkg::IDX_W-1:0]          first_vertex_i,
  input  logic [vna_pkg::IDX_W-1:0]          second_vertex_i,
  input  logic [vna_pkg::IDX_W-1:0]          third_vertex_i,
  input  logic signed [vna_pkg::NRM_W-1:0]   normal_x_i,
  input  logic signed [vna_pkg::NRM_W-1:0]   normal_y_i,
  input  logic signed [vna_pkg::NRM_W-1:0]   normal_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vna_pkg::NRM_W-1:0]   first_avg_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]   first_avg_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]   first_avg_z_o,
  output logic signed [vna_pkg::NRM_W-1:0]   second_avg_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]   second_avg_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]   second_avg_z_o,
  output logic signed [vna_pkg::NRM_W-1:0]   third_avg_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]   third_avg_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]   third_avg_z_o,
  output logic                               status_o
);
  import vna_pkg::*;

  // saturating add of a face normal into a 32-bit sum
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [NRM_W-1:0] b);
    logic signed [SUM_W:0] s;
    logic signed [SUM_W-1:0] r;
    s = {a[SUM_W-1], a} + {{(SUM_W-NRM_W+1){b[NRM_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  // signed quotient from magnitude and sign, clamped to the normal range
  function automatic logic [NRM_W-1:0] clamp_q(input logic [SUM_W-1:0] mag, input logic neg);
    logic [NRM_W-1:0] r;
    logic [SUM_W-1:0] neg_lim;
    logic [SUM_W-1:0] pos_lim;
    neg_lim = SUM_W'(1) << (NRM_W - 1);
    pos_lim = neg_lim - SUM_W'(1);
    if (neg) begin
      r = (mag > neg_lim) ? {1'b1, {(NRM_W-1){1'b0}}} : (~mag[NRM_W-1:0] + NRM_W'(1));
    end else begin
      r = (mag > pos_lim) ? {1'b0, {(NRM_W-1){1'b1}}} : mag[NRM_W-1:0];
    end
    return r;
  endfunction

  // sequencer and counters
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_addr_q;
  logic [1:0]          corner_q;
  logic [1:0]          comp_q;
  logic [STEP_W-1:0]   bit_q;
  logic                out_valid_q;

  // item payload held for the whole item
  logic [IDX_W-1:0]        vtx_q [3];
  logic signed [NRM_W-1:0] nrm_q [3];

  // store and its registered read
  entry_t              store_mem [VERTEX_COUNT];
  entry_t              rd_q;
  entry_t              ent_q;

  // shared divider
  logic [CNT_W-1:0]    rem_q;
  logic [SUM_W-1:0]    quo_q;
  logic                neg_q;

  // result being built and result on offer
  logic [NRM_W-1:0]    avg_q [RES_SLOTS];
  logic                bad_q;
  logic [NRM_W-1:0]    out_avg_q [RES_SLOTS];
  logic                out_status_q;

  // control decoded from the state
  logic                in_accept;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic                out_load;
  action_e             action;

  // divider step and helper values
  logic [CNT_W:0]          div_sh;
  logic [CNT_W+1:0]        div_diff;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [SLOT_W-1:0]       base_slot;
  logic [SLOT_W-1:0]       slot;

  assign action    = action_e'(action_i);
  assign in_accept = in_valid_i && !in_stall_o;

  assign base_slot = SLOT_W'({2'b00, corner_q} * 4'd3);
  assign slot      = base_slot + SLOT_W'(comp_q);

  // one restoring step: shift in the next dividend bit, try to subtract the count
  assign div_sh   = {rem_q, quo_q[SUM_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, ent_q.cnt};

  always_comb begin
    case (comp_q)
      2'd0:    sum_sel = ent_q.sum_x;
      2'd1:    sum_sel = ent_q.sum_y;
      default: sum_sel = ent_q.sum_z;
    endcase
  end
  // magnitude; the most negative sum maps onto 2^31, which still fits unsigned
  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(VERTEX_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (action)
            ACT_ACCUM: state_d = ST_ACC_RD;
            ACT_QUERY: state_d = ST_QRY_RD;
            ACT_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: begin
        state_d = (corner_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
      end
      ST_QRY_RD: state_d = ST_QRY_LOAD;
      ST_QRY_LOAD: begin
        if (rd_q.cnt == '0) begin
          state_d = (corner_q == 2'd2) ? ST_DONE : ST_QRY_RD;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV: begin
        if (bit_q == '0) state_d = ST_DIV_END;
      end
      ST_DIV_END: begin
        if (comp_q != 2'd2) begin
          state_d = ST_DIV_START;
        end else begin
          state_d = (corner_q == 2'd2) ? ST_DONE : ST_QRY_RD;
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = vtx_q[corner_q][ADDR_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = vtx_q[corner_q][ADDR_W-1:0];
    mem_wdata  = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_ACC_RD, ST_QRY_RD: rd_en = 1'b1;
      ST_ACC_WR: begin
        // a saturated count drops this corner's contribution entirely
        mem_we          = (rd_q.cnt != CNT_MAX);
        mem_wdata.sum_x = sat_add(rd_q.sum_x, nrm_q[0]);
        mem_wdata.sum_y = sat_add(rd_q.sum_y, nrm_q[1]);
        mem_wdata.sum_z = sat_add(rd_q.sum_z, nrm_q[2]);
        mem_wdata.cnt   = rd_q.cnt + CNT_W'(1);
      end
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_q <= store_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      corner_q    <= '0;
      comp_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: clr_addr_q <= clr_addr_q + ADDR_W'(1);
        ST_IDLE: begin
          corner_q   <= '0;
          clr_addr_q <= '0;
        end
        ST_ACC_WR: begin
          if (corner_q != 2'd2) corner_q <= corner_q + 2'd1;
        end
        ST_QRY_LOAD: begin
          comp_q <= '0;
          if (rd_q.cnt == '0 && corner_q != 2'd2) corner_q <= corner_q + 2'd1;
        end
        ST_DIV_START: bit_q <= STEP_W'(DIV_STEPS - 1);
        ST_DIV: bit_q <= bit_q - STEP_W'(1);
        ST_DIV_END: begin
          if (comp_q != 2'd2) begin
            comp_q <= comp_q + 2'd1;
          end else if (corner_q != 2'd2) begin
            corner_q <= corner_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q    <= avg_q;
      out_status_q <= bad_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          vtx_q[0] <= first_vertex_i;
          vtx_q[1] <= second_vertex_i;
          vtx_q[2] <= third_vertex_i;
          nrm_q[0] <= normal_x_i;
          nrm_q[1] <= normal_y_i;
          nrm_q[2] <= normal_z_i;
          bad_q    <= 1'b0;
        end
      end
      ST_QRY_LOAD: begin
        ent_q <= rd_q;
        if (rd_q.cnt == '0) begin
          // unused vertex reads as zero and flags the item
          avg_q[base_slot]              <= '0;
          avg_q[base_slot + SLOT_W'(1)] <= '0;
          avg_q[base_slot + SLOT_W'(2)] <= '0;
          bad_q                         <= 1'b1;
        end
      end
      ST_DIV_START: begin
        quo_q <= sum_mag;
        neg_q <= sum_sel[SUM_W-1];
        rem_q <= '0;
      end
      ST_DIV: begin
        if (!div_diff[CNT_W+1]) begin
          rem_q <= div_diff[CNT_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[CNT_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
      end
      ST_DIV_END: avg_q[slot] <= clamp_q(quo_q, neg_q);
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign first_avg_x_o  = out_avg_q[0];
  assign first_avg_y_o  = out_avg_q[1];
  assign first_avg_z_o  = out_avg_q[2];
  assign second_avg_x_o = out_avg_q[3];
  assign second_avg_y_o = out_avg_q[4];
  assign second_avg_z_o = out_avg_q[5];
  assign third_avg_x_o  = out_avg_q[6];
  assign third_avg_y_o  = out_avg_q[7];
  assign third_avg_z_o  = out_avg_q[8];
  assign status_o       = out_status_q;

  `include "vertex_normal_averager_core_assert.svh"

  // a new result only ever comes out of the finished state
  `VNA_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "stray result")
  // divider remainder stays below the divisor once the pass is over
  `VNA_ASSERT_NOW(a_div_rem, state_q == ST_DIV_END, rem_q < ent_q.cnt, "remainder out of range")
  // corner counter never leaves the three corners while an item is at work
  `VNA_ASSERT_NEXT(a_corner_range, state_q != ST_IDLE, corner_q != 2'd3, "corner counter overrun")

endmodule

/* sim/vertex_normal_averager_core_tb.sv */
// testbench for vertex_normal_averager_core: a directed table of faces, then random
// accumulate / query / clear / no-op traffic, each query checked against a hand-written
// result or an in-bench store model; depends on vna_pkg and the core RTL
module vertex_normal_averager_core_tb;
  import vna_pkg::*;

  // action code the core has to ignore
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int unsigned RUN_ITEMS    = 1630;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam longint      CYCLE_LIMIT  = 4000000;

  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint NRM_HI = (longint'(1) <<< (NRM_W - 1)) - 1;
  localparam longint NRM_LO = -NRM_HI - 1;
  localparam logic [NRM_W-1:0] NRM_MAX = {1'b0, {(NRM_W-1){1'b1}}};
  localparam logic [NRM_W-1:0] NRM_MIN = {1'b1, {(NRM_W-1){1'b0}}};

  // one input item: corners and normal axes indexed 0..2 (first..third, x..z)
  typedef struct packed {
    logic [1:0]                 action;
    logic [2:0][IDX_W-1:0]      vtx;
    logic [2:0][NRM_W-1:0]      nrm;
  } face_item_t;

  // one query result: avg[corner][axis]
  typedef struct packed {
    logic [2:0][2:0][NRM_W-1:0] avg;
    logic                       status;
  } avg_result_t;

  typedef struct packed {
    face_item_t  face;
    logic        typed;   // want holds a hand-written result
    avg_result_t want;
  } stim_row_t;

  // all inputs known from time zero
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i        = '0;
  logic [IDX_W-1:0]  first_vertex_i  = '0;
  logic [IDX_W-1:0]  second_vertex_i = '0;
  logic [IDX_W-1:0]  third_vertex_i  = '0;
  logic signed [NRM_W-1:0] normal_x_i = '0;
  logic signed [NRM_W-1:0] normal_y_i = '0;
  logic signed [NRM_W-1:0] normal_z_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic signed [NRM_W-1:0] first_avg_x_o, first_avg_y_o, first_avg_z_o;
  logic signed [NRM_W-1:0] second_avg_x_o, second_avg_y_o, second_avg_z_o;
  logic signed [NRM_W-1:0] third_avg_x_o, third_avg_y_o, third_avg_z_o;
  logic              status_o;

  // model of the per-vertex store and the queries still owed by the core
  entry_t      vtx_store [VERTEX_COUNT];
  avg_result_t pending_avgs [$];
  int unsigned miss_count   = 0;
  bit          calm         = 1'b0;   // no idling on either side while set
  bit          hold_request = 1'b0;   // asks the output side for one long stall

  string corner_name [3] = '{"first", "second", "third"};
  string axis_name [3]   = '{"x", "y", "z"};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vertex_normal_averager_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .third_vertex_i  (third_vertex_i),
    .normal_x_i      (normal_x_i),
    .normal_y_i      (normal_y_i),
    .normal_z_i      (normal_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_avg_x_o   (first_avg_x_o),
    .first_avg_y_o   (first_avg_y_o),
    .first_avg_z_o   (first_avg_z_o),
    .second_avg_x_o  (second_avg_x_o),
    .second_avg_y_o  (second_avg_y_o),
    .second_avg_z_o  (second_avg_z_o),
    .third_avg_x_o   (third_avg_x_o),
    .third_avg_y_o   (third_avg_y_o),
    .third_avg_z_o   (third_avg_z_o),
    .status_o        (status_o)
  );

  // ---------------------------------------------------------------- store model

  function automatic void wipe_store();
    foreach (vtx_store[i]) vtx_store[i] = '0;
  endfunction

  // signed 32-bit accumulate, pinned at the limits
  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [NRM_W-1:0] n);
    longint s;
    s = longint'($signed(acc)) + longint'($signed(n));
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    return s[SUM_W-1:0];
  endfunction

  // one corner hit: a saturated use count drops the whole contribution
  function automatic void add_corner(logic [IDX_W-1:0] idx, logic [2:0][NRM_W-1:0] n);
    if (idx >= VERTEX_COUNT) return;
    if (vtx_store[idx].cnt == CNT_MAX) return;
    vtx_store[idx].sum_x = sat_sum(vtx_store[idx].sum_x, n[0]);
    vtx_store[idx].sum_y = sat_sum(vtx_store[idx].sum_y, n[1]);
    vtx_store[idx].sum_z = sat_sum(vtx_store[idx].sum_z, n[2]);
    vtx_store[idx].cnt   = vtx_store[idx].cnt + 1'b1;
  endfunction

  // sum / count, truncated toward zero, clamped to the normal range
  function automatic logic [NRM_W-1:0] mean_axis(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] cnt);
    longint q;
    q = longint'($signed(sum)) / longint'(cnt);
    if (q > NRM_HI) q = NRM_HI;
    if (q < NRM_LO) q = NRM_LO;
    return q[NRM_W-1:0];
  endfunction

  // applies one accepted item to the store; returns 1 when it yields a result
  function automatic bit apply_face(face_item_t f, output avg_result_t r);
    entry_t e;
    r = '0;
    case (f.action)
      ACT_ACCUM: begin
        // corners go in one after another, so a repeated vertex counts twice
        for (int c = 0; c < 3; c++) add_corner(f.vtx[c], f.nrm);
      end
      ACT_QUERY: begin
        for (int c = 0; c < 3; c++) begin
          if (f.vtx[c] >= VERTEX_COUNT || vtx_store[f.vtx[c]].cnt == '0) begin
            // unused vertex reads as zero and flags the status
            r.status = 1'b1;
          end else begin
            e = vtx_store[f.vtx[c]];
            r.avg[c][0] = mean_axis(e.sum_x, e.cnt);
            r.avg[c][1] = mean_axis(e.sum_y, e.cnt);
            r.avg[c][2] = mean_axis(e.sum_z, e.cnt);
          end
        end
        return 1'b1;
      end
      ACT_CLEAR: wipe_store();
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic face_item_t make_face(logic [1:0] act, int v0, int v1, int v2,
                                           int nx, int ny, int nz);
    face_item_t f;
    f.action = act;
    f.vtx[0] = v0[IDX_W-1:0];
    f.vtx[1] = v1[IDX_W-1:0];
    f.vtx[2] = v2[IDX_W-1:0];
    f.nrm[0] = nx[NRM_W-1:0];
    f.nrm[1] = ny[NRM_W-1:0];
    f.nrm[2] = nz[NRM_W-1:0];
    return f;
  endfunction

  // the same averaged normal on all three corners
  function automatic avg_result_t same_avg(int x, int y, int z, bit st);
    avg_result_t r;
    for (int c = 0; c < 3; c++) begin
      r.avg[c][0] = x[NRM_W-1:0];
      r.avg[c][1] = y[NRM_W-1:0];
      r.avg[c][2] = z[NRM_W-1:0];
    end
    r.status = st;
    return r;
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 4);
  endfunction

  // random item; most corners fall in a 16-vertex window so queries find real sums
  function automatic face_item_t random_face(int unsigned base);
    face_item_t  f;
    int unsigned r;
    r = $urandom_range(999);
    if (r < 15)       f.action = ACT_CLEAR;
    else if (r < 45)  f.action = ACT_NONE;
    else if (r < 560) f.action = ACT_ACCUM;
    else              f.action = ACT_QUERY;
    for (int c = 0; c < 3; c++) begin
      r = $urandom_range(99);
      if (r < 75)      f.vtx[c] = IDX_W'(base + $urandom_range(15));
      else if (r < 82) f.vtx[c] = '0;
      else if (r < 89) f.vtx[c] = '1;
      else             f.vtx[c] = IDX_W'($urandom);
      r = $urandom_range(99);
      if (r < 80)      f.nrm[c] = NRM_W'($urandom);
      else if (r < 87) f.nrm[c] = NRM_MAX;
      else if (r < 94) f.nrm[c] = NRM_MIN;
      else             f.nrm[c] = '0;
    end
    // repeated corner within one face
    if ($urandom_range(9) == 0) f.vtx[1] = f.vtx[0];
    return f;
  endfunction

  // drives one item from a falling edge and holds it until the core takes it;
  // the store model is updated at the accepting edge
  task automatic send_face(face_item_t f, bit typed, avg_result_t want);
    int unsigned gap;
    avg_result_t predicted;
    gap = idle_span();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    action_i        = f.action;
    first_vertex_i  = f.vtx[0];
    second_vertex_i = f.vtx[1];
    third_vertex_i  = f.vtx[2];
    normal_x_i      = f.nrm[0];
    normal_y_i      = f.nrm[1];
    normal_z_i      = f.nrm[2];
    do @(posedge clk_i); while (in_stall_o);
    if (apply_face(f, predicted)) pending_avgs.push_back(typed ? want : predicted);
  endtask

  task automatic flag_miss(string msg);
    miss_count++;
    if (miss_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------- output side

  // random stalls, plus one long hold-off on request while the input keeps coming
  initial begin : result_drain
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left   = HOLD_CYCLES;
        end else begin
          stall_left = idle_span();
        end
      end
      out_stall_i = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // compare each accepted result with the oldest owed query, field by field
  always @(posedge clk_i) begin : result_check
    avg_result_t got;
    avg_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.avg[0][0] = first_avg_x_o;
      got.avg[0][1] = first_avg_y_o;
      got.avg[0][2] = first_avg_z_o;
      got.avg[1][0] = second_avg_x_o;
      got.avg[1][1] = second_avg_y_o;
      got.avg[1][2] = second_avg_z_o;
      got.avg[2][0] = third_avg_x_o;
      got.avg[2][1] = third_avg_y_o;
      got.avg[2][2] = third_avg_z_o;
      got.status    = status_o;
      if (pending_avgs.size() == 0) begin
        flag_miss("result arrived with no query outstanding");
      end else begin
        want = pending_avgs.pop_front();
        for (int c = 0; c < 3; c++) begin
          for (int a = 0; a < 3; a++) begin
            if (got.avg[c][a] !== want.avg[c][a])
              flag_miss($sformatf("%s_avg_%s: expected %0d, got %0d", corner_name[c],
                                  axis_name[a], $signed(want.avg[c][a]),
                                  $signed(got.avg[c][a])));
          end
        end
        if (got.status !== want.status)
          flag_miss($sformatf("status: expected %0b, got %0b", want.status, got.status));
      end
    end
  end

  // ---------------------------------------------------------------- timeout

  initial begin : watchdog
    for (longint cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    stim_row_t   rows [$];
    int unsigned base;
    base = 0;
    wipe_store();

    // directed table: extremes of every field, every action, the special cases
    rows.push_back('{make_face(ACT_QUERY, 0, 4095, 2048, 0, 0, 0), 1'b1, same_avg(0, 0, 0, 1)});
    rows.push_back('{make_face(ACT_NONE, 5, 6, 7, 32767, -32768, 1), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 5, 6, 7, 0, 0, 0), 1'b1, same_avg(0, 0, 0, 1)});
    // one vertex on all three corners
    rows.push_back('{make_face(ACT_ACCUM, 0, 0, 0, 32767, -32768, 0), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 0, 0, 0, 0, 0, 0), 1'b1,
                     same_avg(32767, -32768, 0, 0)});
    rows.push_back('{make_face(ACT_ACCUM, 4095, 1, 0, -32768, 32767, -1), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 0, 4095, 1, 0, 0, 0), 1'b0, '0});
    // small sums of mixed sign: truncation toward zero
    rows.push_back('{make_face(ACT_ACCUM, 100, 101, 102, 1, -1, 16384), 1'b0, '0});
    rows.push_back('{make_face(ACT_ACCUM, 100, 101, 102, -2, 2, -16384), 1'b0, '0});
    rows.push_back('{make_face(ACT_ACCUM, 100, 100, 103, -3, 3, 5), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 100, 101, 102, 0, 0, 0), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 103, 7, 100, 0, 0, 0), 1'b0, '0});
    rows.push_back('{make_face(ACT_ACCUM, 4095, 4095, 4095, 32767, 32767, 32767), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 4095, 0, 1, 0, 0, 0), 1'b0, '0});
    // clear empties everything touched so far
    rows.push_back('{make_face(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 0, 4095, 100, 0, 0, 0), 1'b1, same_avg(0, 0, 0, 1)});
    rows.push_back('{make_face(ACT_ACCUM, 2, 3, 4, 16384, 0, -16384), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 2, 3, 4, 0, 0, 0), 1'b1,
                     same_avg(16384, 0, -16384, 0)});
    rows.push_back('{make_face(ACT_NONE, 2, 3, 4, 1, 1, 1), 1'b0, '0});
    rows.push_back('{make_face(ACT_QUERY, 2, 3, 5, 0, 0, 0), 1'b0, '0});

    // reset once; the core then clears its store before taking any item
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_face(rows[i].face, rows[i].typed, rows[i].want);

    // random traffic in windows of 150 items, some windows without idling
    for (int n = 0; n < RUN_ITEMS; n++) begin
      if (n % 150 == 0) begin
        calm = ($urandom_range(3) == 0);
        base = $urandom_range(VERTEX_COUNT - 16);
      end
      // long output hold-off while items keep coming: the core backs up
      if (n == 400) begin
        calm         = 1'b0;
        hold_request = 1'b1;
      end
      // sender goes quiet and waits until every owed query has come back
      if (n == 900) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (pending_avgs.size() != 0) @(negedge clk_i);
      end
      send_face(random_face(base), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (pending_avgs.size() != 0) @(posedge clk_i);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    miss_count += pending_avgs.size();
    if (miss_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/vna_pkg.sv
hw/rtl/vertex_normal_averager_core.sv
sim/vertex_normal_averager_core_tb.sv
